@@ sv/owtr_pkg.sv @@
// ----------------------------------------------------------------------------
// owtr_pkg - shared types and constants of the one-wire temperature reader
// Bus sequencer phases, configuration register set, command bytes and the
// result record that leaves the block.
// ----------------------------------------------------------------------------
package owtr_pkg;

	// Bus sequencer phases
	typedef enum logic [4:0] {
		PH_IDLE        = 5'd0,
		PH_PRE_HIGH    = 5'd1,
		PH_RST_LOW     = 5'd2,
		PH_PRES_WAIT   = 5'd3,
		PH_PRES_SAMPLE = 5'd4,
		PH_RECOVER     = 5'd5,
		PH_W_LOW       = 5'd6,
		PH_W_DATA      = 5'd7,
		PH_W_REC       = 5'd8,
		PH_W_TAIL      = 5'd9,
		PH_CONVERT     = 5'd10,
		PH_R_LOW       = 5'd11,
		PH_R_WAIT      = 5'd12,
		PH_R_REST      = 5'd13
	} phase_t;

	// Configuration register indexes
	localparam logic [3:0] CFG_PRE_HIGH      = 4'd0;
	localparam logic [3:0] CFG_RESET_LOW     = 4'd1;
	localparam logic [3:0] CFG_PRESENCE_WAIT = 4'd2;
	localparam logic [3:0] CFG_RECOVERY      = 4'd3;
	localparam logic [3:0] CFG_WRITE_SLOT    = 4'd4;
	localparam logic [3:0] CFG_READ_SAMPLE   = 4'd5;
	localparam logic [3:0] CFG_READ_SLOT     = 4'd6;
	localparam logic [3:0] CFG_CONVERT_WAIT  = 4'd7;

	// Register reset values
	localparam logic [7:0]  RST_PRE_HIGH      = 8'd80;
	localparam logic [11:0] RST_RESET_LOW     = 12'd800;
	localparam logic [7:0]  RST_PRESENCE_WAIT = 8'd50;
	localparam logic [9:0]  RST_RECOVERY      = 10'd200;
	localparam logic [6:0]  RST_WRITE_SLOT    = 7'd50;
	localparam logic [5:0]  RST_READ_SAMPLE   = 6'd2;
	localparam logic [6:0]  RST_READ_SLOT     = 7'd40;
	localparam logic [19:0] RST_CONVERT_WAIT  = 20'd1250;

	// Bus commands
	localparam logic [7:0] CMD_SKIP_ROM = 8'hcc;
	localparam logic [7:0] CMD_CONVERT  = 8'h44;
	localparam logic [7:0] CMD_READ_PAD = 8'hbe;

	// Fixed release time after each written byte
	localparam logic [19:0] WRITE_TAIL_TICKS = 20'd40;

	typedef struct packed {
		logic [7:0]  pre_high;
		logic [11:0] reset_low;
		logic [7:0]  presence_wait;
		logic [9:0]  recovery;
		logic [6:0]  write_slot;
		logic [5:0]  read_sample;
		logic [6:0]  read_slot;
		logic [19:0] convert_wait;
	} cfg_t;

	// Sequencer position, without the tick counter
	typedef struct packed {
		phase_t      phase;
		logic [3:0]  bit_idx;
		logic [2:0]  byte_idx;
		logic [7:0]  shift;
		logic        fin;
	} seq_t;

	typedef struct packed {
		logic        drive_low;
		logic        busy_res;
		logic        done_res;
		logic        presence_ok;
		logic [15:0] raw_word;
		logic        is_negative;
		logic [11:0] integer_part;
		logic [6:0]  hundredths;
	} result_t;

endpackage

@@ sv/one_wire_temperature_reader.sv @@
// ----------------------------------------------------------------------------
// one_wire_temperature_reader - one-wire bus master with temperature decode
// Runs reset/presence, skip-ROM, convert, wait, reset/presence, skip-ROM,
// read scratchpad and a 16-bit read, one transaction per microsecond tick,
// and splits the word into sign, integer part and hundredths.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_stall   start_req, line_in
// out       source     out_valid / out_stall drive_low, busy_res, done_res,
//                                            presence_ok, raw_word,
//                                            is_negative, integer_part,
//                                            hundredths
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each input transaction is one bus tick and yields exactly one output
// transaction; the sequencer state and the tick's result are updated in the
// cycle of acceptance, so one tick is taken every cycle unless in_stall
// is high. Results pass through a two-entry output queue and show on
// out_valid in the cycle after acceptance; in_stall rises once both
// entries are held.
// Reset loads the default timing registers and leaves the sequencer idle.
// cfg_ready is always high; writes apply to segments entered on later ticks.

module one_wire_temperature_reader
	import owtr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        start_req,
	input  logic        line_in,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        drive_low,
	output logic        busy_res,
	output logic        done_res,
	output logic        presence_ok,
	output logic [15:0] raw_word,
	output logic        is_negative,
	output logic [11:0] integer_part,
	output logic [6:0]  hundredths,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	// ------------------------------------------------------------------
	// Segment length of a phase; zero means the segment is skipped
	// ------------------------------------------------------------------
	function automatic logic [19:0] seg_len(phase_t p, cfg_t c);
		logic [19:0] len;
		len = 20'd1;
		unique case (p)
			PH_PRE_HIGH:  len = {12'd0, c.pre_high};
			PH_RST_LOW:   len = {8'd0, c.reset_low};
			PH_PRES_WAIT: len = {12'd0, c.presence_wait};
			PH_RECOVER:   len = {10'd0, c.recovery};
			PH_W_DATA:    len = {13'd0, c.write_slot};
			PH_W_TAIL:    len = WRITE_TAIL_TICKS;
			PH_CONVERT:   len = c.convert_wait;
			PH_R_WAIT:    len = (c.read_sample == 6'd0) ? 20'd1 : {14'd0, c.read_sample};
			PH_R_REST:    len = {13'd0, c.read_slot};
			default:      len = 20'd1;
		endcase
		return len;
	endfunction

	// ------------------------------------------------------------------
	// Step to the phase after the current one
	// ------------------------------------------------------------------
	function automatic seq_t leave(seq_t s);
		seq_t n;
		n = s;
		unique case (s.phase)
			PH_PRE_HIGH:    n.phase = PH_RST_LOW;
			PH_RST_LOW:     n.phase = PH_PRES_WAIT;
			PH_PRES_WAIT:   n.phase = PH_PRES_SAMPLE;
			PH_PRES_SAMPLE: n.phase = PH_RECOVER;
			PH_RECOVER: begin
				n.byte_idx = s.byte_idx + 3'd1;
				n.shift    = CMD_SKIP_ROM;
				n.bit_idx  = 4'd0;
				n.phase    = PH_W_LOW;
			end
			PH_W_LOW:       n.phase = PH_W_DATA;
			PH_W_DATA:      n.phase = PH_W_REC;
			PH_W_REC: begin
				n.shift   = {1'b0, s.shift[7:1]};
				n.bit_idx = s.bit_idx + 4'd1;
				n.phase   = (n.bit_idx >= 4'd8) ? PH_W_TAIL : PH_W_LOW;
			end
			PH_W_TAIL: begin
				n.bit_idx = 4'd0;
				priority if (s.byte_idx == 3'd1) begin
					n.byte_idx = 3'd2;
					n.shift    = CMD_CONVERT;
					n.phase    = PH_W_LOW;
				end else if (s.byte_idx == 3'd2) begin
					n.byte_idx = 3'd3;
					n.phase    = PH_CONVERT;
				end else if (s.byte_idx == 3'd5) begin
					n.byte_idx = 3'd6;
					n.shift    = CMD_READ_PAD;
					n.phase    = PH_W_LOW;
				end else begin
					n.byte_idx = 3'd7;
					n.phase    = PH_R_LOW;
				end
			end
			PH_CONVERT: begin
				n.byte_idx = 3'd4;
				n.phase    = PH_PRE_HIGH;
			end
			PH_R_LOW:       n.phase = PH_R_WAIT;
			PH_R_WAIT:      n.phase = PH_R_REST;
			PH_R_REST: begin
				if (s.bit_idx >= 4'd15) begin
					n.bit_idx = 4'd0;
					n.fin     = 1'b1;
					n.phase   = PH_IDLE;
				end else begin
					n.bit_idx = s.bit_idx + 4'd1;
					n.phase   = PH_R_LOW;
				end
			end
			default:        n.phase = PH_IDLE;
		endcase
		return n;
	endfunction

	// ------------------------------------------------------------------
	// Skip zero-length segments; at most four in a row can occur
	// (convert wait, pre-high, reset-low and presence-wait)
	// ------------------------------------------------------------------
	function automatic seq_t skip_empty(seq_t s, cfg_t c);
		seq_t n;
		n = s;
		for (int i = 0; i < 4; i++) begin
			if (n.phase != PH_IDLE && seg_len(n.phase, c) == 20'd0) begin
				n = leave(n);
			end
		end
		return n;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_high      <= RST_PRE_HIGH;
			cfg_q.reset_low     <= RST_RESET_LOW;
			cfg_q.presence_wait <= RST_PRESENCE_WAIT;
			cfg_q.recovery      <= RST_RECOVERY;
			cfg_q.write_slot    <= RST_WRITE_SLOT;
			cfg_q.read_sample   <= RST_READ_SAMPLE;
			cfg_q.read_slot     <= RST_READ_SLOT;
			cfg_q.convert_wait  <= RST_CONVERT_WAIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PRE_HIGH:      cfg_q.pre_high      <= cfg_data[7:0];
				CFG_RESET_LOW:     cfg_q.reset_low     <= cfg_data[11:0];
				CFG_PRESENCE_WAIT: cfg_q.presence_wait <= cfg_data[7:0];
				CFG_RECOVERY:      cfg_q.recovery      <= cfg_data[9:0];
				CFG_WRITE_SLOT:    cfg_q.write_slot    <= cfg_data[6:0];
				CFG_READ_SAMPLE:   cfg_q.read_sample   <= cfg_data[5:0];
				CFG_READ_SLOT:     cfg_q.read_slot     <= cfg_data[6:0];
				CFG_CONVERT_WAIT:  cfg_q.convert_wait  <= cfg_data;
				default: ;  // indexes past the register set are dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer state
	// ------------------------------------------------------------------
	seq_t        seq_q;
	logic [19:0] tick_q;
	logic [15:0] raw_q;
	logic        presence_q;

	seq_t        seq_d;
	logic [19:0] tick_d;
	logic [15:0] raw_d;
	logic        presence_d;
	result_t     res_d;

	logic        push;
	logic        pop;

	// Per-tick work: optional start, this tick's bus action, then advance
	always_comb begin
		seq_t        s;
		logic [19:0] t;
		logic        drv;
		logic        active;
		logic [15:0] mag;
		logic [10:0] frac_scaled;

		s          = seq_q;
		s.fin      = 1'b0;
		t          = tick_q;
		raw_d      = raw_q;
		presence_d = presence_q;
		drv        = 1'b0;
		active     = 1'b1;

		if (seq_q.phase == PH_IDLE) begin
			if (!start_req) begin
				active = 1'b0;
			end else begin
				// start tick is the first tick of the sequence
				s.byte_idx = 3'd0;
				s.bit_idx  = 4'd0;
				s.phase    = PH_PRE_HIGH;
				s          = skip_empty(s, cfg_q);
				t          = seg_len(s.phase, cfg_q);
			end
		end

		if (active) begin
			unique case (s.phase)
				PH_RST_LOW, PH_W_LOW, PH_R_LOW: drv = 1'b1;
				PH_W_DATA:                      drv = ~s.shift[0];
				default:                        drv = 1'b0;
			endcase

			if (s.phase == PH_PRES_SAMPLE) begin
				presence_d = ~line_in;
			end
			// read sample on the last tick of the sample wait
			if (s.phase == PH_R_WAIT && t == 20'd1) begin
				raw_d = {line_in, raw_q[15:1]};
			end

			if (t != 20'd0) begin
				t = t - 20'd1;
			end
			if (t == 20'd0) begin
				s = skip_empty(leave(s), cfg_q);
				t = (s.phase == PH_IDLE) ? 20'd0 : seg_len(s.phase, cfg_q);
			end
		end

		seq_d  = s;
		tick_d = t;

		// Temperature decode of the finished word
		mag         = raw_d[15] ? (~raw_d + 16'd1) : raw_d;
		frac_scaled = {7'd0, mag[3:0]} * 11'd100;

		res_d             = '0;
		res_d.drive_low   = drv;
		res_d.busy_res    = active;
		res_d.presence_ok = presence_d;
		if (s.fin) begin
			res_d.done_res     = 1'b1;
			res_d.raw_word     = raw_d;
			res_d.is_negative  = raw_d[15];
			res_d.integer_part = mag[15:4];
			res_d.hundredths   = frac_scaled[10:4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q.phase    <= PH_IDLE;
			seq_q.bit_idx  <= 4'd0;
			seq_q.byte_idx <= 3'd0;
			seq_q.shift    <= 8'd0;
			seq_q.fin      <= 1'b0;
			tick_q         <= 20'd0;
			raw_q          <= 16'd0;
			presence_q     <= 1'b0;
		end else if (push) begin
			seq_q      <= seq_d;
			tick_q     <= tick_d;
			raw_q      <= raw_d;
			presence_q <= presence_d;
		end
	end

	// ------------------------------------------------------------------
	// Two-entry result queue
	// ------------------------------------------------------------------
	result_t    fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	result_t    head;

	assign in_stall  = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head         = fifo_q[rd_ptr_q];
	assign drive_low    = head.drive_low;
	assign busy_res     = head.busy_res;
	assign done_res     = head.done_res;
	assign presence_ok  = head.presence_ok;
	assign raw_word     = head.raw_word;
	assign is_negative  = head.is_negative;
	assign integer_part = head.integer_part;
	assign hundredths   = head.hundredths;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// an active segment always has ticks left to run
	a_tick_live: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q.phase != PH_IDLE) |-> (tick_q != 20'd0))
		else $error("active phase with empty tick counter");

	// idle tick without start keeps the sequencer idle
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(push && seq_q.phase == PH_IDLE && !start_req) |=> (seq_q.phase == PH_IDLE))
		else $error("sequencer left idle without a start");

	// input backpressure only with a full queue of waiting results
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && cnt_q == 2'd2))
		else $error("input stalled while queue not full");

	// queue occupancy never exceeds two
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue overrun");

endmodule
